[rtl/spdbs_pkg.sv]
`default_nettype none
package spdbs_pkg;

	localparam int TICKS_W   = 12;
	localparam int SLOT_W    = TICKS_W + 1;
	localparam int BIT_IDX_W = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [TICKS_W-1:0]   SYNC_TICKS_RST = TICKS_W'(10);
	localparam logic [TICKS_W-1:0]   BIT_TICKS_RST  = TICKS_W'(10);
	localparam logic [BIT_IDX_W-1:0] LAST_SLOT      = BIT_IDX_W'(15);

	localparam logic [7:0] START_MARK = 8'hFF;
	localparam logic [7:0] END_MARK   = 8'h00;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_CHAR  = 2'd1,
		OP_START = 2'd2,
		OP_END   = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC_TICKS = 1'b0,
		REG_BIT_TICKS  = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_SYNC = 2'd1,
		PH_DATA = 2'd2,
		PH_TAIL = 2'd3
	} phase_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] char_byte;
	} in_item_t;

	typedef struct packed {
		logic sync_level;
		logic data_level;
		logic busy_res;
		logic request_dropped;
	} out_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] reg_index;
		logic [TICKS_W-1:0]   wr_data;
	} cfg_req_t;

endpackage
`default_nettype wire

[rtl/spdbs_chan_if.sv]
`default_nettype none
interface spdbs_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/sync_pulse_doubled_byte_serializer.sv]
`default_nettype none
// Sync-pulse doubled-byte serializer, two-pin transmitter paced by time-base ticks.
// Channels:
//   in_ch  : one request per item; op selects tick, send character, send start
//            marker (0xFF) or send end marker (0x00); char_byte is the character.
//   out_ch : one result per request: sync and data pin levels after the request,
//            busy flag, and a flag set when a send request was dropped while busy.
//   cfg    : register writes (sync_ticks, bit_ticks), always ready; write only
//            while no result is pending.
// A frame: sync high for sync_ticks ticks, the byte MSB first twice (16 slots of
// bit_ticks ticks), then a tail of 2*bit_ticks ticks with data held.
// A result is registered in the output register, or in the skid register if the
// output stalls. Throughput: one request per cycle while the skid register is not
// full; pins update per request by a counter decrement, a compare and a bit select.
// Receiver stall: results go to the output register, then to a single skid
// register; in_ch.ready drops only while the skid register is full.
// Reset: phase idle, both pins low, registers back to 10 ticks, no result pending.
module sync_pulse_doubled_byte_serializer (
	input  wire  clk,
	input  wire  arst_n,
	spdbs_chan_if.sink   in_ch,
	spdbs_chan_if.sink   cfg,
	spdbs_chan_if.source out_ch
);

	// configuration
	logic [spdbs_pkg::TICKS_W-1:0] sync_ticks_q;
	logic [spdbs_pkg::TICKS_W-1:0] bit_ticks_q;
	spdbs_pkg::cfg_req_t           cfg_req;

	// frame state
	spdbs_pkg::phase_t               phase_q, phase_d;
	logic [spdbs_pkg::SLOT_W-1:0]    slot_q, slot_d, slot_dec;
	logic [spdbs_pkg::BIT_IDX_W-1:0] bit_idx_q, bit_idx_d, bit_idx_inc;
	logic [7:0]                      frame_q, frame_d;
	logic                            data_pin_q, data_pin_d;
	logic                            sync_pin_q, sync_pin_d;
	logic                            dropped;

	logic [spdbs_pkg::TICKS_W-1:0] sync_len, bit_len;
	spdbs_pkg::in_item_t           req;
	spdbs_pkg::out_item_t          res;

	// output register and skid register
	spdbs_pkg::out_item_t out_s1, skid_q;
	logic                 out_vld_q, skid_vld_q;
	logic                 accept, pop;

	assign cfg_req   = cfg.payload;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_ticks_q <= spdbs_pkg::SYNC_TICKS_RST;
			bit_ticks_q  <= spdbs_pkg::BIT_TICKS_RST;
		end else if (cfg.valid) begin
			case (cfg_req.reg_index)
				spdbs_pkg::REG_SYNC_TICKS: sync_ticks_q <= cfg_req.wr_data;
				spdbs_pkg::REG_BIT_TICKS:  bit_ticks_q  <= cfg_req.wr_data;
				default: ;
			endcase
		end
	end

	// a zero length acts as one tick
	assign sync_len = (sync_ticks_q == '0) ? spdbs_pkg::TICKS_W'(1) : sync_ticks_q;
	assign bit_len  = (bit_ticks_q == '0) ? spdbs_pkg::TICKS_W'(1) : bit_ticks_q;

	assign req         = in_ch.payload;
	assign slot_dec    = (slot_q != '0) ? slot_q - spdbs_pkg::SLOT_W'(1) : slot_q;
	assign bit_idx_inc = bit_idx_q + spdbs_pkg::BIT_IDX_W'(1);

	// next state
	always_comb begin
		phase_d    = phase_q;
		slot_d     = slot_q;
		bit_idx_d  = bit_idx_q;
		frame_d    = frame_q;
		data_pin_d = data_pin_q;
		sync_pin_d = sync_pin_q;
		dropped    = 1'b0;
		if (req.op == spdbs_pkg::OP_TICK) begin
			if (phase_q != spdbs_pkg::PH_IDLE) begin
				slot_d = slot_dec;
				if (slot_dec == '0) begin
					case (phase_q)
						spdbs_pkg::PH_SYNC: begin
							sync_pin_d = 1'b0;
							phase_d    = spdbs_pkg::PH_DATA;
							bit_idx_d  = '0;
							data_pin_d = frame_q[7];
							slot_d     = {1'b0, bit_len};
						end
						spdbs_pkg::PH_DATA: begin
							if (bit_idx_q == spdbs_pkg::LAST_SLOT) begin
								phase_d = spdbs_pkg::PH_TAIL;
								slot_d  = {bit_len, 1'b0};
							end else begin
								// slot bit: MSB first, each byte sent twice
								bit_idx_d  = bit_idx_inc;
								data_pin_d = frame_q[~bit_idx_inc[2:0]];
								slot_d     = {1'b0, bit_len};
							end
						end
						spdbs_pkg::PH_TAIL: phase_d = spdbs_pkg::PH_IDLE;
						default: ;
					endcase
				end
			end
		end else if (phase_q != spdbs_pkg::PH_IDLE) begin
			dropped = 1'b1;
		end else begin
			case (req.op)
				spdbs_pkg::OP_CHAR:  frame_d = req.char_byte;
				spdbs_pkg::OP_START: frame_d = spdbs_pkg::START_MARK;
				default:             frame_d = spdbs_pkg::END_MARK;
			endcase
			phase_d    = spdbs_pkg::PH_SYNC;
			sync_pin_d = 1'b1;
			bit_idx_d  = '0;
			slot_d     = {1'b0, sync_len};
		end
	end

	// result of this request
	always_comb begin
		res.sync_level      = sync_pin_d;
		res.data_level      = data_pin_d;
		res.busy_res        = (phase_d != spdbs_pkg::PH_IDLE);
		res.request_dropped = dropped;
	end

	assign in_ch.ready = !skid_vld_q;
	assign accept      = in_ch.valid && in_ch.ready;
	assign pop         = out_vld_q && out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= spdbs_pkg::PH_IDLE;
			slot_q     <= '0;
			bit_idx_q  <= '0;
			frame_q    <= '0;
			data_pin_q <= 1'b0;
			sync_pin_q <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_d;
			slot_q     <= slot_d;
			bit_idx_q  <= bit_idx_d;
			frame_q    <= frame_d;
			data_pin_q <= data_pin_d;
			sync_pin_q <= sync_pin_d;
		end
	end

	// advance the output register; park a result in the skid when stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_vld_q) begin
					skid_vld_q <= 1'b0;
				end else if (!accept) begin
					out_vld_q <= 1'b0;
				end
			end
			if (accept) begin
				if (!out_vld_q || pop) begin
					out_vld_q <= 1'b1;
				end else begin
					skid_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_vld_q) begin
			out_s1 <= skid_q;
		end else if (accept && (!out_vld_q || pop)) begin
			out_s1 <= res;
		end
		if (accept && out_vld_q && !pop) begin
			skid_q <= res;
		end
	end

	assign out_ch.valid   = out_vld_q;
	assign out_ch.payload = out_s1;

endmodule
`default_nettype wire

[rtl/spdbs_checker.sv]
`default_nettype none
module spdbs_checker (
	input wire                       clk,
	input wire                       arst_n,
	input wire                       in_valid,
	input wire                       in_ready,
	input wire                       out_valid,
	input wire                       out_ready,
	input wire spdbs_pkg::out_item_t out_payload
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_payload))
		else $error("stalled result changed");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("request refused with no result pending");

	a_drop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_payload.request_dropped |-> out_payload.busy_res)
		else $error("request dropped while idle");

	a_sync_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_payload.sync_level |-> out_payload.busy_res)
		else $error("sync high outside a frame");

endmodule

bind sync_pulse_doubled_byte_serializer spdbs_checker u_spdbs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_payload (out_ch.payload)
);
`default_nettype wire

[tb/sync_pulse_doubled_byte_serializer_tb.sv]
`default_nettype none
module sync_pulse_doubled_byte_serializer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import spdbs_pkg::*;

	logic clk;
	logic arst_n;

	spdbs_chan_if #(.payload_t(in_item_t))  in_ch  ();
	spdbs_chan_if #(.payload_t(cfg_req_t))  cfg    ();
	spdbs_chan_if #(.payload_t(out_item_t)) out_ch ();

	sync_pulse_doubled_byte_serializer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.cfg    (cfg.sink),
		.out_ch (out_ch.source)
	);

	// Pin model of the transmitter: mirrors phase, slot count, bit position and
	// both pin levels. It advances once per accepted request, in request order.
	phase_t               ph         = PH_IDLE;
	logic [SLOT_W-1:0]    slots_left = '0;
	logic [BIT_IDX_W-1:0] slot_idx   = '0;
	logic [7:0]           tx_byte    = '0;
	logic                 sync_pin_q = 1'b0;
	logic                 data_pin_q = 1'b0;
	logic [TICKS_W-1:0]   sync_len   = SYNC_TICKS_RST;
	logic [TICKS_W-1:0]   bit_len    = BIT_TICKS_RST;

	// Pin levels still owed by the block, oldest first.
	out_item_t pending_pins[$];

	int  errors         = 0;
	int  results_seen   = 0;
	int  requests_sent  = 0;
	int  frames_started = 0;
	int  drops_seen     = 0;
	int  settings_used  = 0;
	// Set to run both channels at full rate, with no gaps or stalls.
	bit  quiet          = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A register value of zero counts as one tick.
	function automatic logic [SLOT_W-1:0] ticks_or_one(logic [TICKS_W-1:0] v);
		return (v == '0) ? SLOT_W'(1) : SLOT_W'(v);
	endfunction

	// Apply one request to the pin model and return the pin levels after it.
	function automatic out_item_t predict_pins(in_item_t it);
		out_item_t r;
		logic      dropped;
		dropped = 1'b0;
		if (op_t'(it.op) == OP_TICK) begin
			// A tick only matters while a frame is running.
			if (ph != PH_IDLE) begin
				if (slots_left != '0)
					slots_left = slots_left - 1'b1;
				if (slots_left == '0) begin
					case (ph)
					PH_SYNC: begin
						// Sync pulse over: drop sync, present the MSB.
						sync_pin_q = 1'b0;
						ph         = PH_DATA;
						slot_idx   = '0;
						data_pin_q = tx_byte[7];
						slots_left = ticks_or_one(bit_len);
					end
					PH_DATA: begin
						if (slot_idx == LAST_SLOT) begin
							// Hold the last bit through a tail of two slots.
							ph         = PH_TAIL;
							slots_left = ticks_or_one(bit_len) << 1;
						end else begin
							// MSB first; the byte goes out twice, so wrap at 8.
							slot_idx   = slot_idx + 1'b1;
							data_pin_q = tx_byte[~slot_idx[2:0]];
							slots_left = ticks_or_one(bit_len);
						end
					end
					PH_TAIL: ph = PH_IDLE;
					default: ;
					endcase
				end
			end
		end else if (ph != PH_IDLE) begin
			// Send request while busy: flag it, leave the frame alone.
			dropped = 1'b1;
			drops_seen++;
		end else begin
			case (op_t'(it.op))
			OP_CHAR:  tx_byte = it.char_byte;
			OP_START: tx_byte = START_MARK;
			default:  tx_byte = END_MARK;
			endcase
			// Sync rises on the request itself; the pulse counts from the next tick.
			ph         = PH_SYNC;
			sync_pin_q = 1'b1;
			slot_idx   = '0;
			slots_left = ticks_or_one(sync_len);
			frames_started++;
		end
		r.sync_level      = sync_pin_q;
		r.data_level      = data_pin_q;
		r.busy_res        = (ph != PH_IDLE);
		r.request_dropped = dropped;
		return r;
	endfunction

	// Mostly short gaps, now and then a long one; none while quiet.
	function automatic int idle_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Send one request. Leave valid high on return so back-to-back requests
	// need no second assignment in the same step; settle() drops it.
	task automatic send_request(op_t op, logic [7:0] ch);
		int       gap;
		in_item_t it;
		gap = idle_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.op        = op;
		it.char_byte = ch;
		in_ch.valid   <= 1'b1;
		in_ch.payload <= it;
		do @(posedge clk); while (!in_ch.ready);
		pending_pins.push_back(predict_pins(it));
		requests_sent++;
	endtask

	// Ticks carry random bytes so the ignored field still toggles.
	task automatic tick_n(int n);
		repeat (n) send_request(OP_TICK, 8'($urandom));
	endtask

	task automatic finish_frame();
		while (ph != PH_IDLE)
			tick_n(1);
	endtask

	// Stop requests and wait for every owed result.
	task automatic drain_owed();
		int waited;
		in_ch.valid <= 1'b0;
		waited = 0;
		while (pending_pins.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		// Output register plus skid register: keep clocking after the owed queue empties.
		repeat (3) @(posedge clk);
	endtask

	// Finish the running frame, then drain.
	task automatic settle();
		finish_frame();
		drain_owed();
	endtask

	// Write both registers once the block is idle with nothing pending.
	task automatic write_regs(logic [TICKS_W-1:0] s, logic [TICKS_W-1:0] b);
		settle();
		cfg.valid   <= 1'b1;
		cfg.payload <= cfg_req_t'{reg_index: REG_SYNC_TICKS, wr_data: s};
		do @(posedge clk); while (!cfg.ready);
		sync_len = s;
		// Hold valid high straight into the second write.
		cfg.payload <= cfg_req_t'{reg_index: REG_BIT_TICKS, wr_data: b};
		do @(posedge clk); while (!cfg.ready);
		bit_len = b;
		cfg.valid <= 1'b0;
		settings_used++;
	endtask

	// One send request followed by the ticks that carry its frame. Now and then
	// cut the frame short so the next request lands while busy, or inject a
	// stray send request in the middle of the frame.
	task automatic send_framed(op_t op, logic [7:0] ch);
		int len;
		len = ticks_or_one(sync_len) + 18 * ticks_or_one(bit_len);
		send_request(op, ch);
		case ($urandom_range(0, 19))
		0: tick_n($urandom_range(0, len - 1));
		1: begin
			tick_n($urandom_range(0, len - 1));
			send_request(op_t'($urandom_range(1, 3)), 8'($urandom));
			finish_frame();
		end
		default: tick_n(len);
		endcase
		if ($urandom_range(0, 3) == 0)
			tick_n($urandom_range(1, 4));
	endtask

	// Both pins low after reset, and idle ticks change nothing.
	task automatic test_idle_after_reset();
		tick_n(3);
	endtask

	// Zero registers act as one tick; every send op while busy gets dropped.
	task automatic test_dropped_requests();
		write_regs('0, '0);
		send_request(OP_START, 8'h00);
		send_request(OP_END, 8'hFF);
		send_request(OP_CHAR, 8'h00);
		send_request(OP_START, 8'hFF);
		tick_n(2);
		send_request(OP_CHAR, 8'hFF);
		finish_frame();
		tick_n(2);
	endtask

	// A character frame, then an end marker so data ends low between frames.
	task automatic test_char_then_end();
		write_regs(TICKS_W'(2), TICKS_W'(1));
		send_request(OP_CHAR, 8'h5A);
		finish_frame();
		tick_n(1);
		send_request(OP_END, 8'h00);
		finish_frame();
	endtask

	// Largest register values: sync must stay high well past any short count,
	// and a request inside the pulse is dropped. Run last; the frame is left
	// running so the item count stays small.
	task automatic test_extreme_lengths();
		quiet = 1'b1;
		write_regs('1, '1);
		send_request(OP_CHAR, 8'hA5);
		tick_n(150);
		send_request(OP_CHAR, 8'($urandom));
		tick_n(20);
		quiet = 1'b0;
	endtask

	// Strings framed by start and end markers under a series of short settings.
	task automatic test_random_strings(int budget);
		int                 stop_at;
		logic [TICKS_W-1:0] s;
		logic [TICKS_W-1:0] b;
		stop_at = requests_sent + budget;
		while (requests_sent < stop_at) begin
			case ($urandom_range(0, 7))
			0:       s = '0;
			1:       s = TICKS_W'(1);
			2:       s = TICKS_W'($urandom_range(7, 40));
			default: s = TICKS_W'($urandom_range(2, 6));
			endcase
			case ($urandom_range(0, 5))
			0:       b = '0;
			1:       b = TICKS_W'(1);
			default: b = TICKS_W'($urandom_range(2, 3));
			endcase
			write_regs(s, b);
			quiet = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(1, 2)) begin
				send_framed(OP_START, 8'($urandom));
				repeat ($urandom_range(0, 6))
					send_framed(OP_CHAR, 8'($urandom));
				send_framed(OP_END, 8'($urandom));
			end
			quiet = 1'b0;
		end
	endtask

	task automatic report_mismatch(string what, out_item_t want, out_item_t got);
		errors++;
		if (errors <= 10)
			$display("%0t: %s: expected sync %b data %b busy %b drop %b, ",
				$realtime, what, want.sync_level, want.data_level, want.busy_res,
				want.request_dropped, "got sync %b data %b busy %b drop %b",
				got.sync_level, got.data_level, got.busy_res, got.request_dropped);
	endtask

	// Compare every accepted result against the oldest owed one.
	always @(posedge clk) begin : check_pins
		out_item_t want;
		out_item_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.payload;
			results_seen++;
			if (pending_pins.size() == 0) begin
				report_mismatch("result with nothing owed", '0, got);
			end else begin
				want = pending_pins.pop_front();
				if (got.sync_level !== want.sync_level ||
				    got.data_level !== want.data_level ||
				    got.busy_res !== want.busy_res ||
				    got.request_dropped !== want.request_dropped)
					report_mismatch("pin mismatch", want, got);
			end
		end
	end

	// Receiver: accept in runs, stall for random stretches.
	initial begin : drain_results
		int stall;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			out_ch.ready <= 1'b1;
			repeat (1 + $urandom_range(0, 24)) @(posedge clk);
			stall = idle_gap();
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin
		in_ch.valid   <= 1'b0;
		in_ch.payload <= '0;
		cfg.valid     <= 1'b0;
		cfg.payload   <= '0;
		arst_n        <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_idle_after_reset();
		test_dropped_requests();
		test_char_then_end();
		test_random_strings(850);
		test_extreme_lengths();

		drain_owed();
		repeat (8) @(posedge clk);
		if (pending_pins.size() != 0) begin
			errors++;
			$display("%0d results never arrived", pending_pins.size());
		end

		$display("covered %0d requests: %0d frames started, %0d dropped while busy",
			requests_sent, frames_started, drops_seen);
		$display("checked %0d results over %0d register settings", results_seen,
			settings_used);
		if (errors == 0)
			$display("sync_pulse_doubled_byte_serializer_tb: clean");
		else
			$display("sync_pulse_doubled_byte_serializer_tb: errors");
		$finish;
	end

	// Hang guard: far beyond the slowest correct run.
	initial begin
		#(30_000_000);
		$display("timeout waiting on the block");
		$display("sync_pulse_doubled_byte_serializer_tb: errors");
		$finish;
	end

endmodule
`default_nettype wire
